FILE: design/nqb_pkg.sv
`timescale 1ns / 1ps

package nqb_pkg;

    // Default largest board the search supports
    localparam int MAX_SIZE_DEF = 16;

    // Fixed payload widths
    localparam int REQ_W = 5;
    localparam int ROW_W = 4;
    localparam int COL_W = 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT,
        S_FAIL
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic start;      // load size, clear search state
        logic step;       // one place / advance / backtrack step
        logic emit_init;  // rewind the emit row
        logic load_row;   // load one found word into the output register
        logic load_fail;  // load the not-found word into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic found;      // every row holds a queen
        logic fail;       // search exhausted, or empty board
        logic emit_last;  // emit row is the final row
        logic out_free;   // output register can take a word
    } t_dp_status;

endpackage

FILE: design/nqb_if.sv
`timescale 1ns / 1ps

interface nqb_req_if;
    logic                      valid;
    logic                      ready;
    logic [nqb_pkg::REQ_W-1:0] board_size_req;

    modport source (output valid, output board_size_req, input ready);
    modport sink   (input valid, input board_size_req, output ready);
endinterface

interface nqb_res_if;
    logic                      valid;
    logic                      ready;
    logic                      found;
    logic [nqb_pkg::ROW_W-1:0] row_index;
    logic [nqb_pkg::COL_W-1:0] queen_col;
    logic                      last;

    modport source (output valid, output found, output row_index, output queen_col,
                    output last, input ready);
    modport sink   (input valid, input found, input row_index, input queen_col,
                    input last, output ready);
endinterface

FILE: design/nqb_ctrl.sv
`timescale 1ns / 1ps

module nqb_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  nqb_pkg::t_dp_status i_status,
    output logic                o_req_ready,
    output nqb_pkg::t_dp_cmd    o_cmd
);

    nqb_pkg::t_state r_state;
    nqb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nqb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            nqb_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = nqb_pkg::S_SEARCH;
                end
            end
            nqb_pkg::S_SEARCH: begin
                if (i_status.fail) begin
                    n_state = nqb_pkg::S_FAIL;
                end else if (i_status.found) begin
                    o_cmd.emit_init = 1'b1;
                    n_state         = nqb_pkg::S_EMIT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            nqb_pkg::S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_row = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = nqb_pkg::S_IDLE;
                    end
                end
            end
            nqb_pkg::S_FAIL: begin
                if (i_status.out_free) begin
                    o_cmd.load_fail = 1'b1;
                    n_state         = nqb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nqb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/nqb_dp.sv
`timescale 1ns / 1ps

module nqb_dp #(
    parameter int MAX_SIZE = nqb_pkg::MAX_SIZE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [nqb_pkg::REQ_W-1:0] i_board_size_req,
    input  nqb_pkg::t_dp_cmd          i_cmd,
    input  logic                      i_res_ready,
    output nqb_pkg::t_dp_status       o_status,
    output logic                      o_res_valid,
    output logic                      o_found,
    output logic [nqb_pkg::ROW_W-1:0] o_row_index,
    output logic [nqb_pkg::COL_W-1:0] o_queen_col,
    output logic                      o_last
);

    localparam int SW  = $clog2(MAX_SIZE + 1);   // size, row and trial counters
    localparam int CW  = $clog2(MAX_SIZE);       // column index
    localparam int DW  = 2 * MAX_SIZE - 1;       // diagonal mask bits
    localparam int DIW = $clog2(DW);             // diagonal index

    // Search state
    logic [SW-1:0] r_size, n_size;
    logic [SW-1:0] r_row, n_row;
    logic [SW-1:0] r_trial, n_trial;
    logic [MAX_SIZE-1:0] r_cols, n_cols;
    logic [DW-1:0] r_diag, n_diag;
    logic [DW-1:0] r_anti, n_anti;
    logic [SW-1:0] r_emit_row, n_emit_row;

    // Per-row column store
    logic [CW-1:0] r_qcol [MAX_SIZE];
    logic          w_qc_we;
    logic [CW-1:0] w_qc_wa;
    logic [CW-1:0] w_qc_wd;
    logic [CW-1:0] w_qc_ra;
    logic [CW-1:0] w_qc_rd;

    // Output register
    logic                      r_out_valid, n_out_valid;
    logic                      r_found, n_found;
    logic [nqb_pkg::ROW_W-1:0] r_row_index, n_row_index;
    logic [nqb_pkg::COL_W-1:0] r_queen_col, n_queen_col;
    logic                      r_last, n_last;

    logic [SW-1:0]   w_size_sat;
    logic [SW-1:0]   w_rowm1;
    logic [SW:0]     w_try_diag;
    logic [SW:0]     w_try_anti;
    logic [SW:0]     w_bk_diag;
    logic [SW:0]     w_bk_anti;
    logic            w_free;
    logic            w_out_free;
    logic            w_emit_last;
    logic [CW+3:0]   w_qc_ext;
    logic [SW+3:0]   w_row_ext;

    always_comb begin
        if (32'(i_board_size_req) > MAX_SIZE) begin
            w_size_sat = SW'(MAX_SIZE);
        end else begin
            w_size_sat = SW'(i_board_size_req);
        end
    end

    assign w_rowm1  = r_row - 1'b1;
    assign w_qc_ra  = i_cmd.load_row ? r_emit_row[CW-1:0] : w_rowm1[CW-1:0];
    assign w_qc_rd  = r_qcol[w_qc_ra];

    // Diagonal indexes: row - col + n - 1 and row + col
    assign w_try_diag = (SW+1)'(r_row) + (SW+1)'(r_size) - (SW+1)'(1) - (SW+1)'(r_trial);
    assign w_try_anti = (SW+1)'(r_row) + (SW+1)'(r_trial);
    assign w_bk_diag  = (SW+1)'(w_rowm1) + (SW+1)'(r_size) - (SW+1)'(1)
                        - (SW+1)'(w_qc_rd);
    assign w_bk_anti  = (SW+1)'(w_rowm1) + (SW+1)'(w_qc_rd);

    assign w_free = !r_cols[r_trial[CW-1:0]] && !r_diag[w_try_diag[DIW-1:0]]
                    && !r_anti[w_try_anti[DIW-1:0]];

    assign w_emit_last = (SW'(r_emit_row + 1'b1) == r_size);
    assign w_out_free  = !r_out_valid || i_res_ready;

    assign o_status.found     = (r_row >= r_size) && (r_size != '0);
    assign o_status.fail      = (r_size == '0) || ((r_trial >= r_size) && (r_row == '0));
    assign o_status.emit_last = w_emit_last;
    assign o_status.out_free  = w_out_free;

    assign w_qc_ext  = {4'b0, w_qc_rd};
    assign w_row_ext = {4'b0, r_emit_row};

    // Search step and emit sequencing
    always_comb begin
        n_size     = r_size;
        n_row      = r_row;
        n_trial    = r_trial;
        n_cols     = r_cols;
        n_diag     = r_diag;
        n_anti     = r_anti;
        n_emit_row = r_emit_row;
        w_qc_we    = 1'b0;
        w_qc_wa    = r_row[CW-1:0];
        w_qc_wd    = r_trial[CW-1:0];
        if (i_cmd.start) begin
            n_size  = w_size_sat;
            n_row   = '0;
            n_trial = '0;
            n_cols  = '0;
            n_diag  = '0;
            n_anti  = '0;
        end else if (i_cmd.step) begin
            if (r_trial >= r_size) begin
                // Backtrack: lift the previous row's queen, resume one column on
                n_row   = w_rowm1;
                n_cols[w_qc_rd]              = 1'b0;
                n_diag[w_bk_diag[DIW-1:0]]   = 1'b0;
                n_anti[w_bk_anti[DIW-1:0]]   = 1'b0;
                n_trial = SW'(w_qc_rd) + 1'b1;
            end else if (w_free) begin
                n_cols[r_trial[CW-1:0]]      = 1'b1;
                n_diag[w_try_diag[DIW-1:0]]  = 1'b1;
                n_anti[w_try_anti[DIW-1:0]]  = 1'b1;
                w_qc_we = 1'b1;
                n_row   = r_row + 1'b1;
                n_trial = '0;
            end else begin
                n_trial = r_trial + 1'b1;
            end
        end
        if (i_cmd.emit_init) begin
            n_emit_row = '0;
        end else if (i_cmd.load_row) begin
            n_emit_row = r_emit_row + 1'b1;
        end
    end

    // Output register
    always_comb begin
        n_out_valid = r_out_valid && !i_res_ready;
        n_found     = r_found;
        n_row_index = r_row_index;
        n_queen_col = r_queen_col;
        n_last      = r_last;
        if (i_cmd.load_row) begin
            n_out_valid = 1'b1;
            n_found     = 1'b1;
            n_row_index = w_row_ext[3:0];
            n_queen_col = w_qc_ext[3:0];
            n_last      = w_emit_last;
        end else if (i_cmd.load_fail) begin
            n_out_valid = 1'b1;
            n_found     = 1'b0;
            n_row_index = '0;
            n_queen_col = '0;
            n_last      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= '0;
            r_row       <= '0;
            r_trial     <= '0;
            r_cols      <= '0;
            r_diag      <= '0;
            r_anti      <= '0;
            r_emit_row  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_size      <= n_size;
            r_row       <= n_row;
            r_trial     <= n_trial;
            r_cols      <= n_cols;
            r_diag      <= n_diag;
            r_anti      <= n_anti;
            r_emit_row  <= n_emit_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found     <= n_found;
        r_row_index <= n_row_index;
        r_queen_col <= n_queen_col;
        r_last      <= n_last;
        if (w_qc_we) begin
            r_qcol[w_qc_wa] <= w_qc_wd;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_row_index = r_row_index;
    assign o_queen_col = r_queen_col;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    // Each placed row holds exactly one column, one diagonal and one antidiagonal
    a_cols_match_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_cols) == 32'(r_row))
        else $error("column mask count differs from placed rows");

    a_diags_match_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_diag) == 32'(r_row)) && ($countones(r_anti) == 32'(r_row)))
        else $error("diagonal mask count differs from placed rows");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row <= r_size) && (r_trial <= r_size))
        else $error("row or trial column beyond board size");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_res_ready) |-> !(i_cmd.load_row || i_cmd.load_fail))
        else $error("output word loaded while a held word waits");
`endif

endmodule

FILE: design/n_queens_backtrack_solver.sv
`timescale 1ns / 1ps
// Sequence: take a request, run search steps (place, advance or backtrack) until the
//   board is seen solved or exhausted, then load the result words one by one.
// Requests: the next is taken once the last word is loaded; the search bounds the rate.
// Reset: synchronous active low on i_rst_n; clears the controller, search counters,
//   masks and output valid. No clearing pass: the column store is always written
//   before it is read.

module n_queens_backtrack_solver #(
    parameter int MAX_SIZE = nqb_pkg::MAX_SIZE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nqb_req_if.sink   i_req,
    nqb_res_if.source o_res
);

    nqb_pkg::t_dp_cmd    w_cmd;
    nqb_pkg::t_dp_status w_status;
    logic                w_req_ready;

    // Controller: sequence take, search, emit; hold in search until solved or exhausted
    nqb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (w_status),
        .o_req_ready (w_req_ready),
        .o_cmd       (w_cmd)
    );

    // Datapath: occupancy masks, per-row column store, output register.
    // The output register parts the result side from the search, so a new
    // request is taken while the final word still waits.
    nqb_dp #(
        .MAX_SIZE (MAX_SIZE)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_board_size_req (i_req.board_size_req),
        .i_cmd            (w_cmd),
        .i_res_ready      (o_res.ready),
        .o_status         (w_status),
        .o_res_valid      (o_res.valid),
        .o_found          (o_res.found),
        .o_row_index      (o_res.row_index),
        .o_queen_col      (o_res.queen_col),
        .o_last           (o_res.last)
    );

    assign i_req.ready = w_req_ready;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import nqb_pkg::*;

    localparam int MAX_BOARD   = MAX_SIZE_DEF;
    localparam int DIAG_W      = 2 * MAX_BOARD - 1;
    localparam int RANDOM_REQS = 410;
    // Long searches sit between handshakes; a board of 16 runs to millions of steps.
    localparam int STALL_LIMIT = 32_000_000;
    localparam int HOLD_CYCLES = 3000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] row_index;
        logic [COL_W-1:0] queen_col;
        logic             last;
    } queen_word_t;

    logic clk = 1'b0;
    logic rst_n;

    nqb_req_if req_if ();
    nqb_res_if res_if ();

    n_queens_backtrack_solver u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    logic [REQ_W-1:0] pending_sizes [$];
    queen_word_t      expected_words [$];

    // Every board size, both saturating codes, and the all-ones code.
    logic [REQ_W-1:0] directed_sizes [20] = '{
        5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9,
        5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd24, 5'd31
    };

    int requests_sent;
    int empty_solves;
    int words_checked;
    int mismatches;
    int stall_cycles;
    int hold_left;
    bit hold_done;

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Run the same depth-first search the block runs and queue the words it must emit.
    function automatic void predict_placement(input logic [REQ_W-1:0] size_code);
        int                   n;
        int                   row;
        int                   trial;
        int                   c;
        bit                   done;
        bit                   solved;
        logic [MAX_BOARD-1:0] col_mask;
        logic [DIAG_W-1:0]    diag_mask;
        logic [DIAG_W-1:0]    anti_mask;
        logic [COL_W-1:0]     placed [MAX_BOARD];
        queen_word_t          w;
        n = (size_code > MAX_BOARD) ? MAX_BOARD : int'(size_code);
        row = 0;
        trial = 0;
        col_mask = '0;
        diag_mask = '0;
        anti_mask = '0;
        solved = 1'b0;
        done = (n == 0);
        while (!done) begin
            if (row >= n) begin
                solved = 1'b1;
                done = 1'b1;
            end else if (trial >= n) begin
                // Column range exhausted: back up one row and resume past its queen.
                if (row == 0) begin
                    done = 1'b1;
                end else begin
                    row--;
                    c = placed[row];
                    col_mask[c] = 1'b0;
                    diag_mask[row + n - 1 - c] = 1'b0;
                    anti_mask[row + c] = 1'b0;
                    trial = c + 1;
                end
            end else if (!col_mask[trial] && !diag_mask[row + n - 1 - trial]
                         && !anti_mask[row + trial]) begin
                col_mask[trial] = 1'b1;
                diag_mask[row + n - 1 - trial] = 1'b1;
                anti_mask[row + trial] = 1'b1;
                placed[row] = trial[COL_W-1:0];
                row++;
                trial = 0;
            end else begin
                trial++;
            end
        end
        if (!solved) begin
            empty_solves++;
            w = '{found: 1'b0, row_index: '0, queen_col: '0, last: 1'b1};
            expected_words.push_back(w);
        end else begin
            for (int r = 0; r < n; r++) begin
                w.found = 1'b1;
                w.row_index = r[ROW_W-1:0];
                w.queen_col = placed[r];
                w.last = (r == n - 1);
                expected_words.push_back(w);
            end
        end
    endfunction

    // Request driver: predict on each accepted word, then offer the next one or idle.
    always @(posedge clk) begin
        if (!rst_n) begin
            req_if.valid <= 1'b0;
            req_if.board_size_req <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predict_placement(req_if.board_size_req);
                requests_sent++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_sizes.size() != 0 &&
                    ((requests_sent >= 150 && requests_sent < 220) ||
                     $urandom_range(0, 99) >= 35)) begin
                    req_if.valid <= 1'b1;
                    req_if.board_size_req <= pending_sizes.pop_front();
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each accepted word with the oldest prediction.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                words_checked++;
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected word, row_index", res_if.row_index, 0);
                end else begin
                    if (res_if.found !== expected_words[0].found)
                        report_mismatch("found", res_if.found, expected_words[0].found);
                    if (res_if.row_index !== expected_words[0].row_index)
                        report_mismatch("row_index", res_if.row_index,
                                        expected_words[0].row_index);
                    if (res_if.queen_col !== expected_words[0].queen_col)
                        report_mismatch("queen_col", res_if.queen_col,
                                        expected_words[0].queen_col);
                    if (res_if.last !== expected_words[0].last)
                        report_mismatch("last", res_if.last, expected_words[0].last);
                    void'(expected_words.pop_front());
                end
            end
            // Hold off once for a long stretch so the block backs up into its input.
            if (!hold_done && words_checked >= 600) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= (words_checked >= 300 && words_checked < 500) ||
                                ($urandom_range(0, 99) >= 35);
            end
        end
    end

    // Watchdog: end the run when neither side has moved a word for too long.
    always @(posedge clk) begin
        if (!rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int pick;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.board_size_req = '0;
        res_if.ready = 1'b0;
        foreach (directed_sizes[k])
            pending_sizes.push_back(directed_sizes[k]);
        // Keep most boards small; the large ones dominate run time.
        for (int k = 0; k < RANDOM_REQS; k++) begin
            pick = $urandom_range(0, 999);
            if (pick < 5)
                pending_sizes.push_back(REQ_W'($urandom_range(13, 31)));
            else if (pick < 25)
                pending_sizes.push_back(REQ_W'($urandom_range(11, 12)));
            else
                pending_sizes.push_back(REQ_W'($urandom_range(0, 10)));
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_sizes.size() != 0 || req_if.valid || expected_words.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("testbench: %0d solve requests, %0d of them without a placement",
                 requests_sent, empty_solves);
        $display("testbench: %0d result words checked, %0d mismatches",
                 words_checked, mismatches);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/nqb_pkg.sv
design/nqb_if.sv
design/nqb_ctrl.sv
design/nqb_dp.sv
design/n_queens_backtrack_solver.sv
bench/testbench.sv
